>>> hw/rtl/assert_macros.svh
// Assertion helper macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked at every edge outside reset.
`define ASSERT_IMPL(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
// Implication checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

>>> hw/rtl/ggvc_pkg.sv
// ---------------------------------------------------------------------------
// ggvc_pkg
// Shared types and constants of the go-to-goal velocity controller.
// ---------------------------------------------------------------------------
package ggvc_pkg;

  localparam int CordicStepsDef = 16;
  localparam int PiQ13 = 25736;
  localparam int TwoPiQ13 = 51472;
  localparam logic signed [33:0] HalfPiQ30 = 34'sd1686629713;

  localparam logic [1:0] MODE_STOP = 2'd0;
  localparam logic [1:0] MODE_MOVE = 2'd1;
  localparam logic [1:0] MODE_ROT  = 2'd2;

  localparam logic [2:0] REG_AGAIN = 3'd0;
  localparam logic [2:0] REG_HGAIN = 3'd1;
  localparam logic [2:0] REG_VMAX  = 3'd2;
  localparam logic [2:0] REG_VMIN  = 3'd3;
  localparam logic [2:0] REG_SPIN  = 3'd4;
  localparam logic [2:0] REG_TOL   = 3'd5;
  localparam logic [2:0] REG_THR   = 3'd6;

  typedef struct packed {
    logic        command;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [15:0] heading;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] linear_speed;
    logic [31:0] turn_rate;
    logic [1:0]  mode_out;
  } out_beat_t;

  function automatic logic [33:0] atan_q30(input logic [4:0] i);
    logic [33:0] r;
    case (i)
      5'd0: r = 34'd843314857;
      5'd1: r = 34'd497837830;
      5'd2: r = 34'd263043837;
      5'd3: r = 34'd133525159;
      5'd4: r = 34'd67021687;
      5'd5: r = 34'd33543516;
      5'd6: r = 34'd16775851;
      5'd7: r = 34'd8388437;
      5'd8: r = 34'd4194283;
      5'd9: r = 34'd2097149;
      5'd31: r = 34'd0;
      default: r = 34'd1 << (5'd30 - i);
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/ggvc_stream_if.sv
// ---------------------------------------------------------------------------
// ggvc_stream_if
// Valid/ready channel carrying one beat of payload.
// ---------------------------------------------------------------------------
interface ggvc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/ggvc_sqrt.sv
// ---------------------------------------------------------------------------
// ggvc_sqrt
// Bit-serial integer square root, two radicand bits per cycle.
// ---------------------------------------------------------------------------
module ggvc_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);
  logic [63:0] rad;
  logic [33:0] rem;
  logic [31:0] res;
  logic [5:0]  cnt;
  logic        busy;
  logic [33:0] trial;
  logic [33:0] rem_sh;

  always_comb begin
    rem_sh = {rem[31:0], rad[63:62]};
    trial  = {res, 2'b01};
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      rad  <= radicand;
      rem  <= '0;
      res  <= '0;
      cnt  <= '0;
    end else if (busy) begin
      rad <= {rad[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem <= rem_sh - trial;
        res <= {res[30:0], 1'b1};
      end else begin
        rem <= rem_sh;
        res <= {res[30:0], 1'b0};
      end
      cnt <= cnt + 6'd1;
      if (cnt == 6'd31) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign root = res;

  `include "assert_macros.svh"
  `ASSERT_NEXT(a_sqrt_done_once, clk, rst, done, !done)
  `ASSERT_IMPL(a_sqrt_done_busy, clk, rst, done, !busy)
  `ASSERT_NEXT(a_sqrt_start_busy, clk, rst, start, busy)
endmodule

>>> hw/rtl/go_to_goal_velocity_controller_top.sv
// ---------------------------------------------------------------------------
// go_to_goal_velocity_controller_top
// Go-to-goal controller with rotate-in-place, fixed point, serial datapath.
// ---------------------------------------------------------------------------
// A goal beat (command 0) stores the goal and arms the controller. It
// gives no result. A tick beat (command 1) carries the pose and returns
// one velocity beat. A moving or rotating tick runs through these steps:
//   - form the differences and squares and start the root,
//   - the bit-serial square root (two radicand bits a cycle),
//   - the tolerance check, the speed gain and the clamp,
//   - the vectoring steps for the heading, one step a cycle,
//   - wrap, turn gain, output build and valid.
// A stopped tick goes straight to a zero output beat. An arrival tick
// ends at the tolerance check with a zero beat and stops the controller.
// One item is in work at a time. A finished result sits in the output
// register, and the next input is taken in the cycle after that beat is
// delivered. Registers sit on an APB port at 4*index.
module go_to_goal_velocity_controller_top #(
  parameter int CORDIC_STEPS = ggvc_pkg::CordicStepsDef
) (
  input  logic                 clk,
  input  logic                 rst,
  ggvc_stream_if.sink          in_ch,
  ggvc_stream_if.source        out_ch,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  localparam int SW = $clog2(CORDIC_STEPS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_SQ, S_SQRT_GO, S_SQRT, S_LIN, S_CLAMP,
    S_CORDIC, S_ERR, S_TURN, S_FIN, S_OUT
  } state_t;

  // configuration
  logic [15:0] attraction_gain, heading_gain;
  logic [30:0] max_linear_speed, min_linear_speed, spin_speed, arrive_tolerance;
  logic [14:0] heading_threshold;

  assign pready = 1'b1;
  logic wr;
  assign wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      attraction_gain   <= 16'd128;
      heading_gain      <= 16'd128;
      max_linear_speed  <= 31'd13107;
      min_linear_speed  <= 31'd3277;
      spin_speed        <= 31'd196608;
      arrive_tolerance  <= 31'd249037;
      heading_threshold <= 15'd3277;
    end else if (wr) begin
      unique case (paddr[4:2])
        ggvc_pkg::REG_AGAIN: attraction_gain   <= pwdata[15:0];
        ggvc_pkg::REG_HGAIN: heading_gain      <= pwdata[15:0];
        ggvc_pkg::REG_VMAX:  max_linear_speed  <= pwdata[30:0];
        ggvc_pkg::REG_VMIN:  min_linear_speed  <= pwdata[30:0];
        ggvc_pkg::REG_SPIN:  spin_speed        <= pwdata[30:0];
        ggvc_pkg::REG_TOL:   arrive_tolerance  <= pwdata[30:0];
        ggvc_pkg::REG_THR:   heading_threshold <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      ggvc_pkg::REG_AGAIN: prdata = {16'd0, attraction_gain};
      ggvc_pkg::REG_HGAIN: prdata = {16'd0, heading_gain};
      ggvc_pkg::REG_VMAX:  prdata = {1'b0, max_linear_speed};
      ggvc_pkg::REG_VMIN:  prdata = {1'b0, min_linear_speed};
      ggvc_pkg::REG_SPIN:  prdata = {1'b0, spin_speed};
      ggvc_pkg::REG_TOL:   prdata = {1'b0, arrive_tolerance};
      ggvc_pkg::REG_THR:   prdata = {17'd0, heading_threshold};
      default:             prdata = '0;
    endcase
  end

  // datapath state
  state_t state;
  logic signed [31:0] goal_x, goal_y;
  logic [1:0]  mode;
  logic signed [32:0] dx, dy;
  logic signed [15:0] hd;
  logic [31:0] ax, ay;
  logic        sh;
  logic [63:0] sqx, sqy;
  logic [31:0] distance;
  logic [47:0] prod;
  logic signed [32:0] lin;
  // x grows by the CORDIC gain on a 33-bit vector: 36 bits hold it
  logic signed [35:0] cx, cy;
  logic signed [33:0] cz;
  logic [SW-1:0] step;
  logic signed [17:0] e;
  logic signed [31:0] turn;
  logic        out_valid;
  ggvc_pkg::out_beat_t out_data;

  logic        sq_start, sq_done;
  logic [31:0] sq_root;
  logic [63:0] rad;
  assign rad = sqx + sqy;

  ggvc_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(rad),
    .done(sq_done), .root(sq_root)
  );
  assign sq_start = (state == S_SQRT_GO);

  ggvc_pkg::in_beat_t ib;
  assign ib = in_ch.data;
  assign in_ch.ready = (state == S_IDLE) && !out_valid;
  assign out_ch.valid = out_valid;
  assign out_ch.data = out_data;

  logic signed [32:0] adx, ady;
  assign adx = dx[32] ? -dx : dx;
  assign ady = dy[32] ? -dy : dy;

  logic [5:0] sidx;
  assign sidx = 6'(step);
  logic signed [35:0] xs, ys;
  logic signed [33:0] cz_r;
  assign xs = cx >>> sidx;
  assign ys = cy >>> sidx;
  assign cz_r = (cz + 34'sd65536) >>> 17;

  logic signed [17:0] e0;
  assign e0 = 18'(hd) - 18'(cz_r);
  logic signed [17:0] ew;
  always_comb begin
    ew = e0;
    if (ew >= 18'sd25736) ew = ew - 18'sd51472;
    else if (ew < -18'sd25736) ew = ew + 18'sd51472;
  end
  logic signed [34:0] tprod;
  assign tprod = -(35'($signed({1'b0, heading_gain})) * 35'(e));
  logic [17:0] eabs;
  assign eabs = e[17] ? 18'(-e) : 18'(e);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mode      <= ggvc_pkg::MODE_STOP;
      goal_x    <= '0;
      goal_y    <= '0;
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            if (!ib.command) begin
              goal_x <= ib.pos_x;
              goal_y <= ib.pos_y;
              mode <= (heading_threshold == '0) ? ggvc_pkg::MODE_MOVE
                                                : ggvc_pkg::MODE_ROT;
            end else if (mode != ggvc_pkg::MODE_MOVE &&
                         mode != ggvc_pkg::MODE_ROT) begin
              mode     <= ggvc_pkg::MODE_STOP;
              out_data <= '0;
              state    <= S_OUT;
            end else begin
              dx    <= 33'(goal_x) - 33'($signed(ib.pos_x));
              dy    <= 33'(goal_y) - 33'($signed(ib.pos_y));
              hd    <= ib.heading;
              state <= S_DIFF;
            end
          end
        end
        S_DIFF: begin
          if (adx[32:31] != 2'b00 || ady[32:31] != 2'b00) begin
            ax <= adx[32:1]; ay <= ady[32:1]; sh <= 1'b1;
          end else begin
            ax <= adx[31:0]; ay <= ady[31:0]; sh <= 1'b0;
          end
          state <= S_SQ;
        end
        S_SQ: begin
          sqx <= 64'(ax) * 64'(ax);
          sqy <= 64'(ay) * 64'(ay);
          state <= S_SQRT_GO;
        end
        S_SQRT_GO: state <= S_SQRT;
        S_SQRT: begin
          if (sq_done) begin
            distance <= sh ? {sq_root[30:0], 1'b0} : sq_root;
            state    <= S_LIN;
          end
        end
        S_LIN: begin
          if ({1'b0, distance} < {2'b00, arrive_tolerance}) begin
            mode     <= ggvc_pkg::MODE_STOP;
            out_data <= '0;
            state    <= S_OUT;
          end else begin
            prod  <= 48'(attraction_gain) * 48'(distance);
            state <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          logic signed [40:0] l;
          l = $signed({1'b0, prod[47:8]});
          if (l > 41'($signed({1'b0, max_linear_speed}))) l = 41'(max_linear_speed);
          if (l < 41'($signed({1'b0, min_linear_speed})))
            l = (l > 0) ? 41'(min_linear_speed) : -41'(min_linear_speed);
          lin <= 33'(l);
          if (dx == 0 && dy == 0) begin
            cx <= '0; cy <= '0; cz <= '0;
            step <= SW'(CORDIC_STEPS);
          end else if (dx[32]) begin
            if (!dy[32]) begin
              cx <= 36'(dy); cy <= -36'(dx); cz <= ggvc_pkg::HalfPiQ30;
            end else begin
              cx <= -36'(dy); cy <= 36'(dx); cz <= -ggvc_pkg::HalfPiQ30;
            end
            step <= '0;
          end else begin
            cx <= 36'(dx); cy <= 36'(dy); cz <= '0; step <= '0;
          end
          state <= S_CORDIC;
        end
        S_CORDIC: begin
          if (step == SW'(CORDIC_STEPS)) begin
            state <= S_ERR;
          end else begin
            if (!cy[35]) begin
              cx <= cx + ys; cy <= cy - xs;
              cz <= cz + $signed(ggvc_pkg::atan_q30(step[4:0]));
            end else begin
              cx <= cx - ys; cy <= cy + xs;
              cz <= cz - $signed(ggvc_pkg::atan_q30(step[4:0]));
            end
            step <= step + SW'(1);
          end
        end
        S_ERR: begin
          e <= ew;
          state <= S_TURN;
        end
        S_TURN: begin
          turn  <= 32'(tprod >>> 5);
          state <= S_FIN;
        end
        S_FIN: begin
          if (mode == ggvc_pkg::MODE_ROT) begin
            out_data.linear_speed <= '0;
            // aligned: release to moving in this same tick
            if (eabs < 18'(heading_threshold)) begin
              out_data.turn_rate <= '0;
              out_data.mode_out  <= ggvc_pkg::MODE_MOVE;
              mode <= ggvc_pkg::MODE_MOVE;
            end else begin
              out_data.turn_rate <= turn[31] ? -{1'b0, spin_speed}
                                             : {1'b0, spin_speed};
              out_data.mode_out  <= mode;
            end
          end else begin
            out_data.linear_speed <= lin[31:0];
            out_data.turn_rate    <= turn;
            out_data.mode_out     <= mode;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_no_take_busy, clk, rst, in_ch.ready, !out_valid)
  `ASSERT_IMPL(a_mode_legal, clk, rst, 1'b1, mode != 2'd3)
  `ASSERT_NEXT(a_out_after_fin, clk, rst, state == S_OUT, out_valid)
endmodule
